[rtl/core/banked_timestamp_stack_defines.svh]
// Assertion macros for the RTL file that checks its own behavior.
`ifndef BANKED_TIMESTAMP_STACK_DEFINES_SVH
`define BANKED_TIMESTAMP_STACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define BTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/bts_pkg.sv]
`timescale 1ns / 1ps

package bts_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam int VALUE_W = 32;
  localparam int STAMP_W = 32;
  localparam int IN_BANK_W = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_SCAN_END,
    S_SELECT,
    S_VALUE
  } state_t;

endpackage

[rtl/core/bts_ram.sv]
`timescale 1ns / 1ps

module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/banked_timestamp_stack.sv]
`timescale 1ns / 1ps

// A set of NUM_BANKS stacks that together behave as one LIFO: a push lands on
// the named bank and is stamped from a shared counter, and a pop returns the
// youngest entry across all banks (lowest bank on a tie), or reports empty.
// A push is refused when its bank is full, out of range, or the counter is all
// ones. Every transaction yields exactly one result. A push is written in
// S_PUSH once the output is free. A pop passes S_SCAN, S_SCAN_END, S_SELECT
// and, unless every bank is empty, S_VALUE: the top stamp of each bank is
// read through the single read port of the stamp memory, one bank per cycle,
// then the winning value is read from the value memory. A pending result sits
// in an output register, so a new transaction is taken while it waits.
module banked_timestamp_stack #(
  parameter int NUM_BANKS  = 4,
  parameter int BANK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [1:0]         in_bank,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_popped_value,
  output logic               out_was_empty,
  output logic               out_push_refused
);

  import bts_pkg::*;

  `include "banked_timestamp_stack_defines.svh"

  localparam int STORE = NUM_BANKS * BANK_DEPTH;
  localparam int AW = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int BW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int FW = $clog2(BANK_DEPTH + 1);
  localparam logic [AW-1:0] DEPTH_A = AW'(BANK_DEPTH);
  localparam logic [FW-1:0] FILL_FULL = FW'(BANK_DEPTH);
  localparam logic [BW-1:0] LAST_BANK = BW'(NUM_BANKS - 1);

  state_t state_r, state_nxt;

  logic [IN_BANK_W-1:0] bank_r, bank_nxt;
  logic [VALUE_W-1:0]   value_r, value_nxt;

  logic [FW-1:0] fill_r [NUM_BANKS];
  logic [STAMP_W-1:0] stamp_counter_r, stamp_counter_nxt;

  logic [BW-1:0]      scan_idx_r, scan_idx_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [BW-1:0]      rd_bank_r, rd_bank_nxt;
  logic               found_r, found_nxt;
  logic [BW-1:0]      best_r, best_nxt;
  logic [STAMP_W-1:0] best_stamp_r, best_stamp_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_empty_r, out_empty_nxt;
  logic               out_refused_r, out_refused_nxt;

  logic          out_free;
  logic          out_load;
  logic [BW-1:0] push_bank;
  logic          push_in_range;
  logic          push_ok;
  logic [BW-1:0] fill_idx;
  logic [FW-1:0] fill_rd;
  logic          fill_inc;
  logic          fill_dec;
  logic          better;

  logic               stamp_we, stamp_re;
  logic [AW-1:0]      stamp_waddr, stamp_raddr;
  logic [STAMP_W-1:0] stamp_rdata;
  logic               val_we, val_re;
  logic [AW-1:0]      val_waddr, val_raddr;
  logic [VALUE_W-1:0] val_rdata;

  function automatic logic [AW-1:0] slot_addr(logic [BW-1:0] b, logic [FW-1:0] idx);
    slot_addr = AW'(b) * DEPTH_A + AW'(idx);
  endfunction

  bts_ram #(.WIDTH(STAMP_W), .DEPTH(STORE)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (stamp_counter_r),
    .re    (stamp_re),
    .raddr (stamp_raddr),
    .rdata (stamp_rdata)
  );

  bts_ram #(.WIDTH(VALUE_W), .DEPTH(STORE)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (value_r),
    .re    (val_re),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  assign out_free      = !out_valid_r || out_ready;
  assign push_bank     = BW'(bank_r);
  assign push_in_range = (32'(bank_r) < NUM_BANKS);
  assign push_ok       = push_in_range && (fill_rd != FILL_FULL) && (stamp_counter_r != '1);
  assign fill_rd       = fill_r[fill_idx];
  assign better        = rd_pend_r && (!found_r || (stamp_rdata > best_stamp_r));

  always_comb begin
    case (state_r)
      S_PUSH:  fill_idx = push_bank;
      S_SCAN:  fill_idx = scan_idx_r;
      default: fill_idx = best_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      stamp_counter_r <= STAMP_W'(1);
      out_valid_r     <= 1'b0;
      rd_pend_r       <= 1'b0;
      found_r         <= 1'b0;
      scan_idx_r      <= '0;
      for (int i = 0; i < NUM_BANKS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r         <= state_nxt;
      stamp_counter_r <= stamp_counter_nxt;
      out_valid_r     <= out_valid_nxt;
      rd_pend_r       <= rd_pend_nxt;
      found_r         <= found_nxt;
      scan_idx_r      <= scan_idx_nxt;
      if (fill_inc) begin
        fill_r[fill_idx] <= fill_rd + FW'(1);
      end else if (fill_dec) begin
        fill_r[fill_idx] <= fill_rd - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    bank_r        <= bank_nxt;
    value_r       <= value_nxt;
    rd_bank_r     <= rd_bank_nxt;
    best_r        <= best_nxt;
    best_stamp_r  <= best_stamp_nxt;
    out_value_r   <= out_value_nxt;
    out_empty_r   <= out_empty_nxt;
    out_refused_r <= out_refused_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    bank_nxt          = bank_r;
    value_nxt         = value_r;
    stamp_counter_nxt = stamp_counter_r;
    scan_idx_nxt      = scan_idx_r;
    rd_pend_nxt       = rd_pend_r;
    rd_bank_nxt       = rd_bank_r;
    found_nxt         = found_r;
    best_nxt          = best_r;
    best_stamp_nxt    = best_stamp_r;
    out_value_nxt     = out_value_r;
    out_empty_nxt     = out_empty_r;
    out_refused_nxt   = out_refused_r;
    out_load          = 1'b0;
    in_ready          = 1'b0;
    fill_inc          = 1'b0;
    fill_dec          = 1'b0;
    stamp_we          = 1'b0;
    stamp_waddr       = slot_addr(push_bank, fill_rd);
    stamp_re          = 1'b0;
    stamp_raddr       = slot_addr(scan_idx_r, fill_rd - FW'(1));
    val_we            = 1'b0;
    val_waddr         = slot_addr(push_bank, fill_rd);
    val_re            = 1'b0;
    val_raddr         = slot_addr(best_r, fill_rd - FW'(1));

    if (better) begin
      found_nxt      = 1'b1;
      best_nxt       = rd_bank_r;
      best_stamp_nxt = stamp_rdata;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          bank_nxt     = in_bank;
          value_nxt    = in_value;
          scan_idx_nxt = '0;
          rd_pend_nxt  = 1'b0;
          found_nxt    = 1'b0;
          state_nxt    = (in_operation == OP_POP) ? S_SCAN : S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          if (push_ok) begin
            stamp_we          = 1'b1;
            val_we            = 1'b1;
            fill_inc          = 1'b1;
            stamp_counter_nxt = stamp_counter_r + STAMP_W'(1);
          end
          out_load        = 1'b1;
          out_value_nxt   = '0;
          out_empty_nxt   = 1'b0;
          out_refused_nxt = !push_ok;
          state_nxt       = S_IDLE;
        end
      end
      S_SCAN: begin
        stamp_re    = (fill_rd != '0);
        rd_pend_nxt = (fill_rd != '0);
        rd_bank_nxt = scan_idx_r;
        if (scan_idx_r == LAST_BANK) begin
          state_nxt = S_SCAN_END;
        end else begin
          scan_idx_nxt = scan_idx_r + BW'(1);
        end
      end
      S_SCAN_END: begin
        rd_pend_nxt = 1'b0;
        state_nxt   = S_SELECT;
      end
      S_SELECT: begin
        if (found_r) begin
          val_re    = 1'b1;
          fill_dec  = 1'b1;
          state_nxt = S_VALUE;
        end else if (out_free) begin
          out_load        = 1'b1;
          out_value_nxt   = '0;
          out_empty_nxt   = 1'b1;
          out_refused_nxt = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      S_VALUE: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_value_nxt   = val_rdata;
          out_empty_nxt   = 1'b0;
          out_refused_nxt = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_was_empty    = out_empty_r;
  assign out_push_refused = out_refused_r;

  `BTS_ASSERT_NOW(a_counter_nonzero, 1'b1, stamp_counter_r != '0)
  `BTS_ASSERT_NOW(a_empty_result_clean, out_valid_r && out_empty_r,
                  out_value_r == '0 && !out_refused_r)
  `BTS_ASSERT_NOW(a_winner_nonempty, state_r == S_SELECT && found_r, fill_r[best_r] != '0)
  `BTS_ASSERT_NEXT(a_refused_keeps_counter, state_r == S_PUSH && out_free && !push_ok,
                   $stable(stamp_counter_r))

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import bts_pkg::*;

  localparam int NUM_BANKS  = 4;
  localparam int BANK_DEPTH = 64;
  localparam int RANDOM_OPS = 1050;

  typedef struct {
    logic                      op;
    logic [IN_BANK_W-1:0]      bank;
    logic signed [VALUE_W-1:0] value;
    bit                        wait_drain;
  } stack_cmd_t;

  typedef struct {
    logic signed [VALUE_W-1:0] popped_value;
    logic                      was_empty;
    logic                      push_refused;
  } stack_resp_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_operation = OP_PUSH;
  logic [IN_BANK_W-1:0]      in_bank = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_popped_value;
  logic                      out_was_empty;
  logic                      out_push_refused;

  stack_cmd_t  pending_ops[$];
  stack_resp_t expected_results[$];
  stack_cmd_t  cur_cmd;

  logic signed [VALUE_W-1:0] shadow_value[NUM_BANKS][BANK_DEPTH];
  logic [STAMP_W-1:0]        shadow_stamp[NUM_BANKS][BANK_DEPTH];
  int                        shadow_fill[NUM_BANKS] = '{default: 0};
  logic [STAMP_W-1:0]        shadow_counter = 1;

  int n_total    = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int hold_left  = 0;
  bit hold_done  = 0;

  banked_timestamp_stack #(
    .NUM_BANKS (NUM_BANKS),
    .BANK_DEPTH(BANK_DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_bank         (in_bank),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_popped_value(out_popped_value),
    .out_was_empty   (out_was_empty),
    .out_push_refused(out_push_refused)
  );

  always #10 clk = ~clk;

  function automatic stack_resp_t predict_stack_op(stack_cmd_t c);
    stack_resp_t        r;
    bit                 found;
    int                 best_bank;
    logic [STAMP_W-1:0] best_stamp;
    logic [STAMP_W-1:0] top_stamp;
    r = '{popped_value: '0, was_empty: 1'b0, push_refused: 1'b0};
    found = 0;
    best_bank = 0;
    best_stamp = '0;
    if (c.op == OP_PUSH) begin
      if (int'(c.bank) >= NUM_BANKS || shadow_fill[c.bank] >= BANK_DEPTH ||
          shadow_counter == '1) begin
        r.push_refused = 1'b1;
      end else begin
        shadow_value[c.bank][shadow_fill[c.bank]] = c.value;
        shadow_stamp[c.bank][shadow_fill[c.bank]] = shadow_counter;
        shadow_fill[c.bank]++;
        shadow_counter++;
      end
    end else begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        if (shadow_fill[i] != 0) begin
          top_stamp = shadow_stamp[i][shadow_fill[i]-1];
          if (!found || top_stamp > best_stamp) begin
            found = 1;
            best_bank = i;
            best_stamp = top_stamp;
          end
        end
      end
      if (!found) begin
        r.was_empty = 1'b1;
      end else begin
        shadow_fill[best_bank]--;
        r.popped_value = shadow_value[best_bank][shadow_fill[best_bank]];
      end
    end
    return r;
  endfunction

  function automatic int sender_idle_pct();
    if (n_accepted < n_total / 3) return 8;
    if (n_accepted < 2 * n_total / 3) return 56;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (n_checked < n_total / 3) return 56;
    if (n_checked < 2 * n_total / 3) return 8;
    return 0;
  endfunction

  task automatic add_op(logic op, logic [IN_BANK_W-1:0] bank,
                        logic signed [VALUE_W-1:0] value, bit wait_drain);
    stack_cmd_t c;
    c.op = op;
    c.bank = bank;
    c.value = value;
    c.wait_drain = wait_drain;
    pending_ops.insert(pending_ops.size(), c);
  endtask

  always @(posedge clk) begin
    stack_resp_t r;
    logic        offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r = predict_stack_op(cur_cmd);
        expected_results.insert(expected_results.size(), r);
        n_accepted++;
      end
      if (in_valid && !in_ready) begin
        offer = 1'b1;
      end else if (pending_ops.size() == 0) begin
        offer = 1'b0;
      end else if (pending_ops[0].wait_drain && n_accepted != n_checked) begin
        offer = 1'b0;
      end else if ($urandom_range(0, 99) < sender_idle_pct()) begin
        offer = 1'b0;
      end else begin
        cur_cmd = pending_ops.pop_front();
        in_operation <= cur_cmd.op;
        in_bank <= cur_cmd.bank;
        in_value <= cur_cmd.value;
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  always @(posedge clk) begin
    stack_resp_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: value %0d empty %0b refused %0b",
                   $time, out_popped_value, out_was_empty, out_push_refused);
          n_errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_popped_value !== exp_r.popped_value) begin
            $display("%0t: popped_value expected %0d actual %0d",
                     $time, exp_r.popped_value, out_popped_value);
            n_errors++;
          end
          if (out_was_empty !== exp_r.was_empty) begin
            $display("%0t: was_empty expected %0b actual %0b",
                     $time, exp_r.was_empty, out_was_empty);
            n_errors++;
          end
          if (out_push_refused !== exp_r.push_refused) begin
            $display("%0t: push_refused expected %0b actual %0b",
                     $time, exp_r.push_refused, out_push_refused);
            n_errors++;
          end
        end
        n_checked++;
      end
      if (!hold_done && n_checked == 200) begin
        hold_done = 1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
    end
  end

  initial begin
    int                        seg_len;
    int                        push_pct;
    bit                        one_bank;
    logic [IN_BANK_W-1:0]      seg_bank;
    logic [IN_BANK_W-1:0]      bank;
    logic signed [VALUE_W-1:0] value;
    logic                      op;
    int                        n_random;

    add_op(OP_POP, 2'd0, 32'sh1234_5678, 0);
    add_op(OP_PUSH, 2'd0, 32'sh7FFF_FFFF, 0);
    add_op(OP_PUSH, 2'd1, 32'sh8000_0000, 0);
    add_op(OP_PUSH, 2'd2, 32'sh0000_0000, 0);
    add_op(OP_PUSH, 2'd3, -32'sd1, 0);
    add_op(OP_PUSH, 2'd0, 32'sh5555_5555, 0);
    add_op(OP_PUSH, 2'd3, 32'shAAAA_AAAA, 0);
    add_op(OP_POP, 2'd3, 32'sh0, 0);
    add_op(OP_PUSH, 2'd2, 32'sh0F0F_F0F0, 0);
    for (int i = 0; i < 7; i++) add_op(OP_POP, 2'(i), -32'sd1, 0);
    add_op(OP_POP, 2'd1, 32'sh0, 0);

    n_random = 0;
    while (n_random < RANDOM_OPS) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_pct = 90;
        4, 5, 6:    push_pct = 15;
        default:    push_pct = 50;
      endcase
      one_bank = 1'($urandom_range(0, 1));
      seg_bank = IN_BANK_W'($urandom_range(0, NUM_BANKS - 1));
      for (int i = 0; i < seg_len && n_random < RANDOM_OPS; i++) begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        bank = one_bank ? seg_bank : IN_BANK_W'($urandom_range(0, 3));
        case ($urandom_range(0, 15))
          0:       value = 32'sh8000_0000;
          1:       value = 32'sh7FFF_FFFF;
          2:       value = -32'sd1;
          3:       value = 32'sh0;
          default: value = $urandom;
        endcase
        add_op(op, bank, value, (i == 0) && (n_random == 0 || $urandom_range(0, 5) == 0));
        n_random++;
      end
    end
    n_total = pending_ops.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_accepted == n_total);
    wait (n_checked == n_accepted);
    repeat (50) @(posedge clk);

    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[banked_timestamp_stack.f]
+incdir+rtl/core
rtl/core/bts_pkg.sv
rtl/core/bts_ram.sv
rtl/core/banked_timestamp_stack.sv
verif/tb.sv
